### rtl/pfba_pkg.sv
// pfba_pkg: shared types and constants of the per-frame bump allocator
// used by pfba_alu, pfba_csr and per_frame_bump_allocator; no dependencies
package pfba_pkg;

   // internal address width: slot * region + pointer + alignment + size stays below 2^39
   localparam int CW = 40;
   // shared adder width, one guard bit so that its top bit flags a negative difference
   localparam int ALU_W = CW + 1;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ALIGN   = 2'd2;

   // configuration reset values
   localparam logic [31:0] RESET_REGION_SIZE = 32'd1048576;
   localparam logic [3:0]  RESET_FRAMES      = 4'd2;
   localparam logic [4:0]  RESET_MIN_ALIGN   = 5'd8;

   // input item actions
   localparam logic ACT_BEGIN_FRAME = 1'b0;
   localparam logic ACT_ALLOCATE    = 1'b1;

   typedef struct packed {
      logic [31:0] region_size;
      logic [3:0]  frames;
      logic [4:0]  min_align;
   } cfg_type;

   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic             sub;
   } alu_req_type;

endpackage

### rtl/per_frame_bump_allocator.sv
// per_frame_bump_allocator: top level, sequencer and datapath registers
// depends on pfba_pkg, pfba_alu and pfba_csr
//
// Linear allocator over a buffer cut into equal per-frame regions. A begin-frame item
// selects slot frame_index mod frames_in_flight and rewinds that region's pointer; an
// allocate item aligns the pointer to 2^max(align_log2, min_align_log2) and grants the
// span if it ends inside the region and below 2^ADDR_WIDTH. Each item gives exactly one
// result item. The block takes one item at a time: req_ready is high only while the
// sequencer is idle. A begin frame runs 32 steps of a restoring remainder, one bit
// of frame_index per cycle, then the result step. An allocate runs a shift-add
// multiply for the region start, one bit of the slot per cycle (at least one multiply
// step), then eight add or compare steps and the result step; a span refused by the
// region check skips the address check and the used and peak steps, one refused by
// the address check skips the used and peak steps; a zero-size allocate goes straight
// to the result step. All of this arithmetic goes through one shared adder. A finished
// result waits in the output register until rsp_ready; the next item is taken meanwhile,
// and its own result step waits for as long as the earlier result is still held.
module per_frame_bump_allocator
   import pfba_pkg::*;
#(
   parameter int ADDR_WIDTH = 32,
   parameter int MAX_FRAMES = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_action,
   input  logic [31:0]          req_frame_index,
   input  logic [31:0]          req_request_size,
   input  logic [4:0]           req_align_log2,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_ok,
   output logic [31:0]          rsp_offset,
   output logic [31:0]          rsp_used_bytes,
   output logic [31:0]          rsp_peak_usage,
   output logic [31:0]          rsp_alloc_count,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int FW     = $clog2(MAX_FRAMES + 1);
   // address limit; at or beyond the internal width no span can reach it
   localparam int LIM_SH = (ADDR_WIDTH < CW) ? ADDR_WIDTH : CW;
   localparam logic [ALU_W-1:0] ADDR_LIMIT = ALU_W'(1) << LIM_SH;

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DIV   = 4'd1;
   localparam logic [3:0] ST_MUL   = 4'd2;
   localparam logic [3:0] ST_REND  = 4'd3;
   localparam logic [3:0] ST_CUR   = 4'd4;
   localparam logic [3:0] ST_ALN   = 4'd5;
   localparam logic [3:0] ST_END   = 4'd6;
   localparam logic [3:0] ST_CHK_R = 4'd7;
   localparam logic [3:0] ST_CHK_A = 4'd8;
   localparam logic [3:0] ST_USED  = 4'd9;
   localparam logic [3:0] ST_PEAK  = 4'd10;
   localparam logic [3:0] ST_EMIT  = 4'd11;

   cfg_type cfg;

   pfba_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   alu_req_type      alu_req;
   logic [ALU_W-1:0] alu_sum;
   logic             alu_neg;

   pfba_alu u_alu (
      .req (alu_req),
      .sum (alu_sum)
   );

   assign alu_neg = alu_sum[ALU_W-1];

   // control
   logic [3:0]        state_ff, state_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   // allocator state
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [31:0]       next_free_ff, next_free_in;
   logic [31:0]       peak_ff, peak_in;
   logic [31:0]       count_ff, count_in;
   // per-item working registers
   logic              action_ff, action_in;
   logic              fail_ff, fail_in;
   logic              peak_up_ff, peak_up_in;
   logic [31:0]       div_sh_ff, div_sh_in;
   logic [SLOT_W-1:0] rem_ff, rem_in;
   logic [SLOT_W-1:0] mul_sh_ff, mul_sh_in;
   logic [31:0]       size_ff, size_in;
   logic [31:0]       mask_ff, mask_in;
   logic [CW-1:0]     acc_ff, acc_in;
   logic [CW-1:0]     start_ff, start_in;
   logic [CW-1:0]     rend_ff, rend_in;
   logic [CW-1:0]     aligned_ff, aligned_in;
   logic [31:0]       used_ff, used_in;
   // result register
   logic              ok_ff, ok_in;
   logic [31:0]       offset_ff, offset_in;
   logic [31:0]       used_out_ff, used_out_in;
   logic [31:0]       peak_out_ff, peak_out_in;
   logic [31:0]       count_out_ff, count_out_in;

   logic [FW-1:0]     frames_eff;
   logic [4:0]        lg;
   logic [SLOT_W:0]   rem_shift;

   // zero frames acts as one, too many as the maximum
   always_comb begin
      priority if (cfg.frames == 4'd0) begin
         frames_eff = FW'(1);
      end else if (32'(cfg.frames) > MAX_FRAMES) begin
         frames_eff = FW'(MAX_FRAMES);
      end else begin
         frames_eff = FW'(cfg.frames);
      end
   end

   assign lg        = (req_align_log2 > cfg.min_align) ? req_align_log2 : cfg.min_align;
   assign rem_shift = {rem_ff, div_sh_ff[31]};
   assign req_ready = (state_ff == ST_IDLE);

   // shared adder operand selection
   always_comb begin
      alu_req.a   = '0;
      alu_req.b   = '0;
      alu_req.sub = 1'b0;
      unique case (state_ff)
         ST_DIV: begin
            alu_req.a   = ALU_W'(rem_shift);
            alu_req.b   = ALU_W'(frames_eff);
            alu_req.sub = 1'b1;
         end
         ST_MUL: begin
            alu_req.a = ALU_W'({acc_ff, 1'b0});
            alu_req.b = mul_sh_ff[SLOT_W-1] ? ALU_W'(cfg.region_size) : '0;
         end
         ST_REND: begin
            alu_req.a = ALU_W'(acc_ff);
            alu_req.b = ALU_W'(cfg.region_size);
         end
         ST_CUR: begin
            alu_req.a = ALU_W'(start_ff);
            alu_req.b = ALU_W'(next_free_ff);
         end
         ST_ALN: begin
            alu_req.a = ALU_W'(acc_ff);
            alu_req.b = ALU_W'(mask_ff);
         end
         ST_END: begin
            alu_req.a = ALU_W'(acc_ff);
            alu_req.b = ALU_W'(size_ff);
         end
         ST_CHK_R: begin
            // region end minus span end, negative means no room
            alu_req.a   = ALU_W'(rend_ff);
            alu_req.b   = ALU_W'(acc_ff);
            alu_req.sub = 1'b1;
         end
         ST_CHK_A: begin
            alu_req.a   = ADDR_LIMIT;
            alu_req.b   = ALU_W'(acc_ff);
            alu_req.sub = 1'b1;
         end
         ST_USED: begin
            alu_req.a   = ALU_W'(acc_ff);
            alu_req.b   = ALU_W'(start_ff);
            alu_req.sub = 1'b1;
         end
         ST_PEAK: begin
            alu_req.a   = ALU_W'(peak_ff);
            alu_req.b   = ALU_W'(used_ff);
            alu_req.sub = 1'b1;
         end
         default: begin
            alu_req.a   = '0;
            alu_req.b   = '0;
            alu_req.sub = 1'b0;
         end
      endcase
   end

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      slot_in      = slot_ff;
      next_free_in = next_free_ff;
      peak_in      = peak_ff;
      count_in     = count_ff;
      action_in    = action_ff;
      fail_in      = fail_ff;
      peak_up_in   = peak_up_ff;
      div_sh_in    = div_sh_ff;
      rem_in       = rem_ff;
      mul_sh_in    = mul_sh_ff;
      size_in      = size_ff;
      mask_in      = mask_ff;
      acc_in       = acc_ff;
      start_in     = start_ff;
      rend_in      = rend_ff;
      aligned_in   = aligned_ff;
      used_in      = used_ff;
      ok_in        = ok_ff;
      offset_in    = offset_ff;
      used_out_in  = used_out_ff;
      peak_out_in  = peak_out_ff;
      count_out_in = count_out_ff;

      // result taken downstream
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               action_in  = req_action;
               div_sh_in  = req_frame_index;
               size_in    = req_request_size;
               mask_in    = ~(32'hFFFF_FFFF << lg);
               rem_in     = '0;
               acc_in     = '0;
               mul_sh_in  = slot_ff;
               cnt_in     = '0;
               fail_in    = 1'b0;
               peak_up_in = 1'b0;
               priority if (req_action == ACT_BEGIN_FRAME) begin
                  state_in = ST_DIV;
               end else if (req_request_size == 32'd0) begin
                  // zero size fails at once
                  fail_in  = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_DIV: begin
            // restoring remainder, one dividend bit a cycle
            rem_in    = alu_neg ? rem_shift[SLOT_W-1:0] : alu_sum[SLOT_W-1:0];
            div_sh_in = {div_sh_ff[30:0], 1'b0};
            cnt_in    = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = ST_EMIT;
            end
         end
         ST_MUL: begin
            // shift-add of the slot, most significant bit first
            acc_in    = alu_sum[CW-1:0];
            mul_sh_in = mul_sh_ff << 1;
            cnt_in    = cnt_ff + 5'd1;
            if (cnt_ff == 5'(SLOT_W - 1)) begin
               state_in = ST_REND;
            end
         end
         ST_REND: begin
            start_in = acc_ff;
            rend_in  = alu_sum[CW-1:0];
            state_in = ST_CUR;
         end
         ST_CUR: begin
            acc_in   = alu_sum[CW-1:0];
            state_in = ST_ALN;
         end
         ST_ALN: begin
            acc_in     = alu_sum[CW-1:0] & ~CW'(mask_ff);
            aligned_in = alu_sum[CW-1:0] & ~CW'(mask_ff);
            state_in   = ST_END;
         end
         ST_END: begin
            acc_in   = alu_sum[CW-1:0];
            state_in = ST_CHK_R;
         end
         ST_CHK_R: begin
            if (alu_neg) begin
               fail_in  = 1'b1;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_CHK_A;
            end
         end
         ST_CHK_A: begin
            if (alu_neg) begin
               fail_in  = 1'b1;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_USED;
            end
         end
         ST_USED: begin
            // span ends inside the region, so used fits in 32 bits
            used_in  = alu_sum[31:0];
            state_in = ST_PEAK;
         end
         ST_PEAK: begin
            peak_up_in = alu_neg;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            // wait while an earlier result is still held
            if (!rsp_valid_ff || rsp_ready) begin
               priority if (action_ff == ACT_BEGIN_FRAME) begin
                  slot_in      = rem_ff;
                  next_free_in = '0;
                  count_in     = '0;
                  ok_in        = 1'b1;
                  offset_in    = '0;
                  used_out_in  = '0;
                  peak_out_in  = peak_ff;
                  count_out_in = '0;
               end else if (fail_ff) begin
                  ok_in        = 1'b0;
                  offset_in    = '0;
                  used_out_in  = next_free_ff;
                  peak_out_in  = peak_ff;
                  count_out_in = count_ff;
               end else begin
                  next_free_in = used_ff;
                  count_in     = (count_ff == 32'hFFFF_FFFF) ? count_ff : count_ff + 32'd1;
                  peak_in      = peak_up_ff ? used_ff : peak_ff;
                  ok_in        = 1'b1;
                  offset_in    = aligned_ff[31:0];
                  used_out_in  = used_ff;
                  peak_out_in  = peak_up_ff ? used_ff : peak_ff;
                  count_out_in = (count_ff == 32'hFFFF_FFFF) ? count_ff : count_ff + 32'd1;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         slot_ff      <= '0;
         next_free_ff <= '0;
         peak_ff      <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
         next_free_ff <= next_free_in;
         peak_ff      <= peak_in;
         count_ff     <= count_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      action_ff    <= action_in;
      fail_ff      <= fail_in;
      peak_up_ff   <= peak_up_in;
      div_sh_ff    <= div_sh_in;
      rem_ff       <= rem_in;
      mul_sh_ff    <= mul_sh_in;
      size_ff      <= size_in;
      mask_ff      <= mask_in;
      acc_ff       <= acc_in;
      start_ff     <= start_in;
      rend_ff      <= rend_in;
      aligned_ff   <= aligned_in;
      used_ff      <= used_in;
      ok_ff        <= ok_in;
      offset_ff    <= offset_in;
      used_out_ff  <= used_out_in;
      peak_out_ff  <= peak_out_in;
      count_out_ff <= count_out_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = ok_ff;
   assign rsp_offset      = offset_ff;
   assign rsp_used_bytes  = used_out_ff;
   assign rsp_peak_usage  = peak_out_ff;
   assign rsp_alloc_count = count_out_ff;

endmodule

### rtl/pfba_alu.sv
// pfba_alu: the one shared add / subtract / compare unit of the allocator
// depends on pfba_pkg
module pfba_alu
   import pfba_pkg::*;
(
   input  alu_req_type      req,
   output logic [ALU_W-1:0] sum
);

   logic [ALU_W-1:0] b_eff;

   assign b_eff = req.sub ? ~req.b : req.b;
   // a - b when sub: top bit set means a < b for zero-extended operands
   assign sum   = req.a + b_eff + ALU_W'(req.sub);

endmodule

### rtl/pfba_csr.sv
// pfba_csr: configuration registers of the allocator, written through the csr channel
// depends on pfba_pkg
module pfba_csr
   import pfba_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   output cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_REGION_SIZE: cfg_in.region_size = csr_wdata;
            CSR_FRAMES:      cfg_in.frames      = csr_wdata[3:0];
            CSR_MIN_ALIGN:   cfg_in.min_align   = csr_wdata[4:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.region_size <= RESET_REGION_SIZE;
         cfg_ff.frames      <= RESET_FRAMES;
         cfg_ff.min_align   <= RESET_MIN_ALIGN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### verif/per_frame_bump_allocator_tb.sv
// per_frame_bump_allocator_tb: self-checking testbench of the per-frame bump allocator
// depends on pfba_pkg and per_frame_bump_allocator; directed cases, then random frames
// of allocations under random stalls on both sides, checked against an in-bench predictor
module per_frame_bump_allocator_tb;
   import pfba_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ADDR_W      = 32;
   localparam int MAX_FR      = 8;
   // slowest item is a begin frame; with both sides stalling the whole run
   // stays well below a tenth of this
   localparam int CYCLE_LIMIT = 400000;
   localparam int END_WAIT    = 40;

   // one expected result item
   typedef struct packed {
      logic        ok;
      logic [31:0] offset;
      logic [31:0] used;
      logic [31:0] peak;
      logic [31:0] count;
   } grant_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_action;
   logic [31:0]          req_frame_index;
   logic [31:0]          req_request_size;
   logic [4:0]           req_align_log2;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_ok;
   logic [31:0]          rsp_offset;
   logic [31:0]          rsp_used_bytes;
   logic [31:0]          rsp_peak_usage;
   logic [31:0]          rsp_alloc_count;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;

   // shadow copy of the registers
   logic [31:0] sh_region;
   logic [3:0]  sh_frames;
   logic [4:0]  sh_min_align;

   // shadow copy of the allocator state
   logic [2:0]  sh_slot;
   logic [32:0] sh_next_free;
   logic [31:0] sh_peak;
   logic [31:0] sh_count;

   grant_type grant_q[$];
   int     errors;
   int     cycle_count;
   bit     idle_on;
   int     hold_left;
   logic [31:0] frame_ctr;

   per_frame_bump_allocator #(
      .ADDR_WIDTH(ADDR_W),
      .MAX_FRAMES(MAX_FR)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_frame_index(req_frame_index),
      .req_request_size(req_request_size),
      .req_align_log2(req_align_log2),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_ok(rsp_ok),
      .rsp_offset(rsp_offset),
      .rsp_used_bytes(rsp_used_bytes),
      .rsp_peak_usage(rsp_peak_usage),
      .rsp_alloc_count(rsp_alloc_count),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL per_frame_bump_allocator");
         $finish;
      end
   end

   // next state and result of the allocator for one accepted item
   function automatic grant_type predict_grant(input logic act, input logic [31:0] fidx,
                                               input logic [31:0] size,
                                               input logic [4:0] alog);
      grant_type   g;
      logic [3:0]  eff;
      logic [4:0]  lg;
      logic [63:0] align;
      logic [63:0] base;
      logic [63:0] region_limit;
      logic [63:0] cur;
      logic [63:0] aligned;
      logic [63:0] span_end;
      logic [63:0] used;
      eff = (sh_frames == 4'd0) ? 4'd1 : ((sh_frames > MAX_FR) ? 4'(MAX_FR) : sh_frames);
      g.ok = 1'b0;
      g.offset = '0;
      if (act == ACT_BEGIN_FRAME) begin
         // rewind: slot follows the frame number, pointer and count restart
         sh_slot = 3'(fidx % {28'd0, eff});
         sh_next_free = '0;
         sh_count = '0;
         g.ok = 1'b1;
      end else if (size != 32'd0) begin
         lg = (alog > sh_min_align) ? alog : sh_min_align;
         align = 64'd1 << lg;
         base = {61'd0, sh_slot} * {32'd0, sh_region};
         region_limit = base + {32'd0, sh_region};
         cur = base + {31'd0, sh_next_free};
         aligned = (cur + align - 64'd1) & ~(align - 64'd1);
         span_end = aligned + {32'd0, size};
         // a span past the region or past the address space is refused, state kept
         if (span_end <= region_limit && span_end <= (64'd1 << ADDR_W)) begin
            used = span_end - base;
            sh_next_free = used[32:0];
            if (sh_count != 32'hFFFF_FFFF) sh_count = sh_count + 32'd1;
            if (used[31:0] > sh_peak) sh_peak = used[31:0];
            g.ok = 1'b1;
            g.offset = aligned[31:0];
         end
      end
      g.used = sh_next_free[31:0];
      g.peak = sh_peak;
      g.count = sh_count;
      return g;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns mismatch %s: got %h expected %h", $time, what, got, want);
      errors++;
   endtask

   // result checker: every accepted result against the oldest expectation
   always @(posedge clock) begin
      grant_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (grant_q.size() == 0) begin
            report_mismatch("unexpected result", {31'd0, rsp_ok}, 32'd0);
         end else begin
            w = grant_q.pop_front();
            if (rsp_ok !== w.ok) report_mismatch("ok", {31'd0, rsp_ok}, {31'd0, w.ok});
            if (rsp_offset !== w.offset) report_mismatch("offset", rsp_offset, w.offset);
            if (rsp_used_bytes !== w.used) report_mismatch("used_bytes", rsp_used_bytes, w.used);
            if (rsp_peak_usage !== w.peak) report_mismatch("peak_usage", rsp_peak_usage, w.peak);
            if (rsp_alloc_count !== w.count)
               report_mismatch("alloc_count", rsp_alloc_count, w.count);
         end
      end
   end

   // receiver: long hold-off on request, random stall bursts while idling is on
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // offer one item, optionally after an idle burst; returns at the accepting edge
   task automatic send_item(input logic act, input logic [31:0] fidx,
                            input logic [31:0] size, input logic [4:0] alog);
      int gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_frame_index <= fidx;
      req_request_size <= size;
      req_align_log2 <= alog;
      do @(posedge clock); while (!req_ready);
      grant_q.push_back(predict_grant(act, fidx, size, alog));
   endtask

   // sender pause until every outstanding result is back
   task automatic wait_results;
      @(negedge clock);
      req_valid <= 1'b0;
      while (grant_q.size() != 0) @(posedge clock);
   endtask

   // register write, only issued while the block is idle
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_REGION_SIZE: sh_region = data;
         CSR_FRAMES:      sh_frames = data[3:0];
         CSR_MIN_ALIGN:   sh_min_align = data[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed;
      // reset registers: 1 MiB regions, two frames, 256-byte minimum alignment
      // allocate before any begin frame lands in slot 0
      send_item(ACT_ALLOCATE, 32'd0, 32'd100, 5'd0);
      // zero size fails
      send_item(ACT_ALLOCATE, 32'd0, 32'd0, 5'd0);
      // requested alignment above the minimum
      send_item(ACT_ALLOCATE, 32'd0, 32'd1, 5'd16);
      // no room left
      send_item(ACT_ALLOCATE, 32'd0, 32'd1048576, 5'd0);
      send_item(ACT_ALLOCATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
      // odd frame number selects slot 1, then an alignment far past the region
      send_item(ACT_BEGIN_FRAME, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
      send_item(ACT_ALLOCATE, 32'd0, 32'd1, 5'd31);
      // exact fit of a whole region, then nothing more fits
      send_item(ACT_BEGIN_FRAME, 32'd0, 32'd0, 5'd0);
      send_item(ACT_ALLOCATE, 32'd0, 32'd1048576, 5'd0);
      send_item(ACT_ALLOCATE, 32'd0, 32'd1, 5'd0);
      wait_results();
      // frames zero acts as one, largest region
      write_csr(CSR_MIN_ALIGN, 32'd0);
      write_csr(CSR_FRAMES, 32'd0);
      write_csr(CSR_REGION_SIZE, 32'hFFFF_FFFF);
      send_item(ACT_BEGIN_FRAME, 32'd5, 32'd0, 5'd0);
      send_item(ACT_ALLOCATE, 32'd0, 32'd3, 5'd0);
      wait_results();
      // slot 1 starts at 2^32-1: one byte fits at the top of the space, the next byte is past it
      write_csr(CSR_FRAMES, 32'd2);
      send_item(ACT_BEGIN_FRAME, 32'd1, 32'd0, 5'd0);
      send_item(ACT_ALLOCATE, 32'd0, 32'd1, 5'd0);
      send_item(ACT_ALLOCATE, 32'd0, 32'd1, 5'd0);
      wait_results();
      // too many frames acts as the maximum, slot 7 lies past the address space
      write_csr(CSR_FRAMES, 32'd15);
      send_item(ACT_BEGIN_FRAME, 32'hFFFF_FFFF, 32'd0, 5'd0);
      send_item(ACT_ALLOCATE, 32'd0, 32'd1, 5'd0);
      wait_results();
      // one-byte regions with the largest minimum alignment, then none
      write_csr(CSR_REGION_SIZE, 32'd1);
      write_csr(CSR_MIN_ALIGN, 32'd31);
      send_item(ACT_BEGIN_FRAME, 32'd6, 32'd0, 5'd0);
      send_item(ACT_ALLOCATE, 32'd0, 32'd1, 5'd0);
      wait_results();
      write_csr(CSR_MIN_ALIGN, 32'd0);
      send_item(ACT_ALLOCATE, 32'd0, 32'd1, 5'd0);
      wait_results();
      // region shrunk mid-frame: pointer past the end until the next begin frame
      write_csr(CSR_REGION_SIZE, RESET_REGION_SIZE);
      write_csr(CSR_FRAMES, {28'd0, RESET_FRAMES});
      write_csr(CSR_MIN_ALIGN, {27'd0, RESET_MIN_ALIGN});
      send_item(ACT_BEGIN_FRAME, 32'd2, 32'd0, 5'd0);
      send_item(ACT_ALLOCATE, 32'd0, 32'd4096, 5'd0);
      wait_results();
      write_csr(CSR_REGION_SIZE, 32'd1024);
      send_item(ACT_ALLOCATE, 32'd0, 32'd1, 5'd0);
      send_item(ACT_BEGIN_FRAME, 32'd3, 32'd0, 5'd0);
      send_item(ACT_ALLOCATE, 32'd0, 32'd1, 5'd0);
      wait_results();
   endtask

   // one random item: mostly allocations sized to fit, some begin frames and noise
   task automatic send_random_item;
      logic        act;
      logic [31:0] fidx;
      logic [31:0] size;
      logic [31:0] cap;
      logic [4:0]  alog;
      act = ($urandom_range(0, 7) == 0) ? ACT_BEGIN_FRAME : ACT_ALLOCATE;
      if (act == ACT_BEGIN_FRAME && $urandom_range(0, 3) != 0) begin
         frame_ctr = frame_ctr + 32'd1;
         fidx = frame_ctr;
      end else begin
         fidx = $urandom;
      end
      cap = (sh_region >> 4) == 32'd0 ? 32'd1 : (sh_region >> 4);
      case ($urandom_range(0, 15))
         0:       size = 32'd0;
         1:       size = $urandom;
         2:       size = sh_region;
         3:       size = $urandom_range(1, 16);
         default: size = $urandom_range(1, cap);
      endcase
      alog = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 6));
      send_item(act, fidx, size, alog);
   endtask

   task automatic test_random_allocation(input int phases, input int per_phase);
      logic [31:0] region;
      logic [31:0] frames;
      logic [31:0] min_align;
      for (int p = 0; p < phases; p++) begin
         wait_results();
         case ($urandom_range(0, 5))
            0:       region = $urandom_range(1, 64);
            1:       region = $urandom_range(256, 65536);
            2:       region = RESET_REGION_SIZE;
            3:       region = $urandom;
            4:       region = 32'hFFFF_FFFF;
            default: region = $urandom_range(32'h0010_0000, 32'h1000_0000);
         endcase
         if (region == 32'd0) region = 32'd1;
         frames = $urandom_range(0, 15);
         min_align = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 31) : $urandom_range(0, 8);
         write_csr(CSR_REGION_SIZE, region);
         write_csr(CSR_FRAMES, frames);
         write_csr(CSR_MIN_ALIGN, min_align);
         for (int i = 0; i < per_phase; i++) send_random_item();
      end
      wait_results();
   endtask

   // receiver holds off while the sender keeps offering, so the input stalls
   task automatic test_backpressure;
      wait_results();
      write_csr(CSR_REGION_SIZE, 32'd65536);
      write_csr(CSR_FRAMES, 32'd4);
      write_csr(CSR_MIN_ALIGN, 32'd4);
      hold_left = 250;
      for (int i = 0; i < 16; i++) send_random_item();
      wait_results();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_BEGIN_FRAME;
      req_frame_index = '0;
      req_request_size = '0;
      req_align_log2 = '0;
      csr_valid = 1'b0;
      csr_index = CSR_REGION_SIZE;
      csr_wdata = '0;
      errors = 0;
      cycle_count = 0;
      idle_on = 1'b1;
      hold_left = 0;
      frame_ctr = '0;
      sh_region = RESET_REGION_SIZE;
      sh_frames = RESET_FRAMES;
      sh_min_align = RESET_MIN_ALIGN;
      sh_slot = '0;
      sh_next_free = '0;
      sh_peak = '0;
      sh_count = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_allocation(10, 100);
      // last part runs without idling
      idle_on = 1'b0;
      test_backpressure();
      test_random_allocation(2, 100);

      // let any stray result show up before closing
      repeat (END_WAIT) @(posedge clock);
      if (grant_q.size() != 0)
         report_mismatch("results missing", grant_q.size(), 32'd0);
      if (errors == 0)
         $display("PASS per_frame_bump_allocator");
      else
         $display("FAIL per_frame_bump_allocator");
      $finish;
   end

endmodule
